// ===== hw/rtl/olt_pkg.sv =====
// Shared types and constants for the ordered list table.
// No dependencies; every other file in hw/rtl but olt_ram imports this package.
`timescale 1ns / 1ps

package olt_pkg;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    // Default list capacity
    localparam int DEPTH_DEFAULT = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STAT_W-1:0] ST_DUMP     = 3'd5;

    // One classified command waiting in the queue
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
    } q_item_t;

endpackage

// ===== hw/rtl/olt_cmd_if.sv =====
// Command channel: valid/ready handshake carrying cmd and value.
// Depends on olt_pkg for field widths.
`timescale 1ns / 1ps

interface olt_cmd_if
    import olt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== hw/rtl/olt_res_if.sv =====
// Result channel: valid/ready handshake carrying status, data and last.
// Depends on olt_pkg for field widths.
`timescale 1ns / 1ps

interface olt_res_if
    import olt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] data;
    logic                    last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== hw/rtl/ordered_list_table.sv =====
// Channel | Dir | Word                        | Accepted when
// in      | in  | cmd[2:0], value[31:0]       | in.valid && in.ready
// out     | out | status[2:0], data[31:0], last | out.valid && out.ready
//
// Insert and clear complete in the back end's idle state. Search, delete and dump
// walk the entry RAM one entry per cycle, a dump only while its results are taken;
// a delete hit stops at the match and moves each later entry down one per cycle.
// Reset clears the count and queue; entries are undefined and get no clearing pass.
// A two-word command queue lets the input side run ahead while results stall.
// Undefined command codes are accepted and dropped with no result.
//
// Top level: ties together front end, command queue and back end.
// Depends on olt_pkg, olt_cmd_if, olt_res_if, olt_front, olt_queue, olt_back.
`timescale 1ns / 1ps

module ordered_list_table
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    olt_cmd_if.sink   in,
    olt_res_if.source out
);

    logic    q_push, q_full, q_pop, q_valid;
    q_item_t q_in, q_head;

    olt_front u_front (
        .in     (in),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    olt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    olt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .out     (out)
    );

endmodule

// ===== hw/rtl/olt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module olt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/olt_front.sv =====
// Front end: takes command words, drops undefined codes, queues the rest.
// Depends on olt_pkg and olt_cmd_if.
`timescale 1ns / 1ps

module olt_front
    import olt_pkg::*;
(
    olt_cmd_if.sink   in,
    input  logic      q_full,
    output logic      q_push,
    output q_item_t   q_item
);

    logic cmd_known;

    // Only the five defined commands reach the back end
    always_comb
    begin
        case (in.cmd)
            CMD_INSERT, CMD_SEARCH, CMD_DUMP, CMD_DELETE, CMD_CLEAR: cmd_known = 1'b1;
            default:                                                cmd_known = 1'b0;
        endcase
    end

    assign in.ready     = !q_full;
    assign q_push       = in.valid && !q_full && cmd_known;
    assign q_item.cmd   = in.cmd;
    assign q_item.value = in.value;

endmodule

// ===== hw/rtl/olt_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on olt_pkg for the queued word type.
`timescale 1ns / 1ps

module olt_queue
    import olt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output q_item_t head
);

    q_item_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/olt_back.sv =====
// Back end: owns the entry RAM and count, runs each command, drives results.
// Depends on olt_pkg, olt_res_if and olt_ram.
`timescale 1ns / 1ps

module olt_back
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  q_item_t   q_item,
    output logic      q_pop,
    olt_res_if.source out
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CMD_W-1:0]        op_reg, op_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic signed [VAL_W-1:0] data_reg, data_next;
    logic                    last_reg, last_next;

    logic                    rd_en, wr_en;
    logic [IDX_W-1:0]        rd_addr, wr_addr;
    logic [VAL_W-1:0]        wr_data, rd_data;

    logic                    out_free, emit, hit, at_end, shift_end;
    logic [STAT_W-1:0]       e_status;
    logic signed [VAL_W-1:0] e_data;
    logic                    e_last;
    logic [CNT_W-1:0]        idx_ext, idx_p1, idx_p2;

    olt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || out.ready;
    assign idx_ext   = CNT_W'(idx_reg);
    assign idx_p1    = idx_ext + CNT_W'(1);
    assign idx_p2    = idx_ext + CNT_W'(2);
    assign hit       = (rd_data == val_reg);
    assign at_end    = (idx_p1 == count_reg);
    assign shift_end = (idx_p2 == count_reg);

    // Command sequencer: rd_data holds entry idx_reg (WALK) or idx_reg+1 (SHIFT)
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_p1[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_data     = '0;
        e_last     = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.cmd)
                        CMD_INSERT:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                                if (count_reg == FULL_CNT)
                                begin
                                    e_status = ST_FULL;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[IDX_W-1:0];
                                    wr_data    = q_item.value;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                                if (count_reg == '0)
                                begin
                                    e_status = ST_EMPTY;
                                end
                                else
                                begin
                                    count_next = '0;
                                end
                            end
                        end
                        CMD_SEARCH, CMD_DUMP, CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                if (out_free)
                                begin
                                    q_pop    = 1'b1;
                                    emit     = 1'b1;
                                    e_status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                // start the walk at the head entry
                                q_pop      = 1'b1;
                                op_next    = q_item.cmd;
                                val_next   = q_item.value;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                case (op_reg)
                    CMD_DUMP:
                    begin
                        if (out_free)
                        begin
                            emit     = 1'b1;
                            e_status = ST_DUMP;
                            e_data   = rd_data;
                            e_last   = at_end;
                            if (at_end)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = idx_p1[IDX_W-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        // search or delete
                        if (hit && op_reg == CMD_DELETE && !at_end)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_SHIFT;
                        end
                        else if (hit || at_end)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                state_next = S_IDLE;
                                if (!hit)
                                begin
                                    e_status = ST_NOTFOUND;
                                end
                                else if (op_reg == CMD_SEARCH)
                                begin
                                    e_status = ST_FOUND;
                                    e_data   = val_reg;
                                end
                                else
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            idx_next = idx_p1[IDX_W-1:0];
                        end
                    end
                endcase
            end

            S_SHIFT:
            begin
                // move entry idx+1 down into idx
                if (shift_end)
                begin
                    if (out_free)
                    begin
                        wr_en      = 1'b1;
                        emit       = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_p2[IDX_W-1:0];
                    idx_next = idx_p1[IDX_W-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = e_status;
            data_next      = e_data;
            last_next      = e_last;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign out.valid  = out_valid_reg;
    assign out.status = status_reg;
    assign out.data   = data_reg;
    assign out.last   = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("count exceeds capacity");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_SHIFT) |-> count_reg != '0)
        else $error("walk on empty list");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_IDLE || state_reg == S_SHIFT))
        else $error("RAM write outside insert or compaction");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_status == ST_FULL) |-> count_reg == FULL_CNT)
        else $error("full reported on a list with room");

    a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrites a word not yet taken");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for ordered_list_table: directed and random list commands with a
// self-checking list tracker. Depends on olt_pkg, olt_cmd_if, olt_res_if and the RTL.
`timescale 1ns / 1ps

module tb_top
    import olt_pkg::*;
;

    localparam int LIST_DEPTH     = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS   = 232;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 120;
    localparam int WATCHDOG_LIMIT = 5000;

    // Command codes the block drops without a result
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        bit                      drain_first;
    } cmd_word_t;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] data;
        logic                    last;
    } list_result_t;

    logic clk;
    logic rst_n;

    olt_cmd_if cmd_ch ();
    olt_res_if res_ch ();

    ordered_list_table #(
        .DEPTH (LIST_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (cmd_ch),
        .out   (res_ch)
    );

    // Tracked list contents and the results still owed by the block
    logic signed [VAL_W-1:0] list_entries [LIST_DEPTH];
    int                      list_count;
    list_result_t            due_results [$];
    cmd_word_t               cmd_backlog [$];

    int errors        = 0;
    int words_in      = 0;
    int results_seen  = 0;
    int status_hits [8];
    int burst_left    = 8;
    int gap_left      = 0;
    int quiet_cycles  = 0;
    int stall_cycles  = 0;
    int hold_left     = 0;
    bit long_hold_done = 1'b0;
    int rx_mode       = 0;
    int rx_phase_left = 0;
    int rx_tick       = 0;
    logic signed [VAL_W-1:0] value_pool [8];

    function automatic void add_due(input logic [STAT_W-1:0] status,
                                    input logic signed [VAL_W-1:0] data,
                                    input logic last);
        list_result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        due_results.push_back(r);
    endfunction

    // Apply one command to the tracked list and record the results it owes
    function automatic void apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic signed [VAL_W-1:0] value);
        int hit;
        hit = -1;
        case (cmd)
            CMD_INSERT:
                if (list_count >= LIST_DEPTH)
                    add_due(ST_FULL, '0, 1'b1);
                else
                begin
                    list_entries[list_count] = value;
                    list_count++;
                    add_due(ST_OK, '0, 1'b1);
                end
            CMD_SEARCH:
                if (list_count == 0)
                    add_due(ST_EMPTY, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < list_count; i++)
                        if (hit < 0 && list_entries[i] == value)
                            hit = i;
                    if (hit >= 0)
                        add_due(ST_FOUND, value, 1'b1);
                    else
                        add_due(ST_NOTFOUND, '0, 1'b1);
                end
            CMD_DUMP:
                if (list_count == 0)
                    add_due(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_count; i++)
                        add_due(ST_DUMP, list_entries[i], i == list_count - 1);
            CMD_DELETE:
                if (list_count == 0)
                    add_due(ST_EMPTY, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < list_count; i++)
                        if (hit < 0 && list_entries[i] == value)
                            hit = i;
                    if (hit < 0)
                        add_due(ST_NOTFOUND, '0, 1'b1);
                    else
                    begin
                        // close the gap left by the removed entry
                        for (int j = hit; j + 1 < list_count; j++)
                            list_entries[j] = list_entries[j + 1];
                        list_count--;
                        add_due(ST_OK, '0, 1'b1);
                    end
                end
            CMD_CLEAR:
                if (list_count == 0)
                    add_due(ST_EMPTY, '0, 1'b1);
                else
                begin
                    list_count = 0;
                    add_due(ST_OK, '0, 1'b1);
                end
            default:
                ;
        endcase
    endfunction

    function automatic void queue_cmd(input logic [CMD_W-1:0] cmd,
                                      input logic signed [VAL_W-1:0] value,
                                      input bit drain_first);
        cmd_word_t w;
        w.cmd         = cmd;
        w.value       = value;
        w.drain_first = drain_first;
        cmd_backlog.push_back(w);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Command driver: bursts of words with random gaps
    always @(posedge clk)
    begin
        cmd_word_t nxt;
        bit        take;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            take = cmd_ch.valid && cmd_ch.ready;
            if (take)
            begin
                apply_list_cmd(cmd_ch.cmd, cmd_ch.value);
                words_in <= words_in + 1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(30, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 15);
                    end
                end
            end
            if (due_results.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            // hold an offered word, sit out a gap, or offer the next one
            if (cmd_ch.valid && !take)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0 &&
                     (!cmd_backlog[0].drain_first ||
                      (due_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES)))
            begin
                nxt = cmd_backlog.pop_front();
                cmd_ch.cmd   <= nxt.cmd;
                cmd_ch.value <= nxt.value;
                cmd_ch.valid <= 1'b1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Result receiver: stall pattern of its own plus one long hold-off
    always @(posedge clk)
    begin
        logic nxt_ready;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            rx_tick++;
            if (!long_hold_done && words_in >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                nxt_ready      = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_mode       = $urandom_range(0, 2);
                    rx_phase_left = $urandom_range(8, 60);
                end
                else
                    rx_phase_left--;
                case (rx_mode)
                    0:       nxt_ready = 1'b1;
                    1:       nxt_ready = 1'($urandom_range(0, 1));
                    default: nxt_ready = (rx_tick % 4) == 0;
                endcase
            end
            res_ch.ready <= nxt_ready;
        end
    end

    // Result monitor: compare each word with the oldest owed result
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            status_hits[res_ch.status]++;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got status %0d data %0d last %0b",
                         $time, res_ch.status, res_ch.data, res_ch.last);
                errors++;
            end
            else
            begin
                exp_r = due_results.pop_front();
                if (res_ch.status !== exp_r.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, exp_r.status, res_ch.status);
                    errors++;
                end
                if (res_ch.data !== exp_r.data)
                begin
                    $display("%0t: data mismatch: expected %0d, got %0d",
                             $time, exp_r.data, res_ch.data);
                    errors++;
                end
                if (res_ch.last !== exp_r.last)
                begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, exp_r.last, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("%0t: timeout with %0d results still owed", $time, due_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        int                      legal;
        int                      r;
        logic [CMD_W-1:0]        c;
        logic signed [VAL_W-1:0] v;

        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = '0;
        cmd_ch.value = '0;
        res_ch.ready = 1'b0;
        list_count   = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        // empty-list cases
        queue_cmd(CMD_SEARCH, 32'sd5, 1'b0);
        queue_cmd(CMD_DELETE, 32'sd5, 1'b0);
        queue_cmd(CMD_CLEAR,  32'sd0, 1'b0);
        queue_cmd(CMD_DUMP,   32'sd0, 1'b0);
        // fill to capacity, extremes first, with a duplicate of -1
        queue_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
        queue_cmd(CMD_INSERT, 32'sd0, 1'b0);
        queue_cmd(CMD_INSERT, -32'sd1, 1'b0);
        for (int k = 0; k < LIST_DEPTH - 4; k++)
        begin
            v = (k == 5) ? -32'sd1 : $signed(32'(k + 1) * 32'h1357_9bdf);
            queue_cmd(CMD_INSERT, v, 1'b0);
        end
        // full list, whole dump, hits and misses
        queue_cmd(CMD_INSERT, 32'sd99, 1'b0);
        queue_cmd(CMD_DUMP,   32'sd0, 1'b0);
        queue_cmd(CMD_SEARCH, 32'sh7fff_ffff, 1'b0);
        queue_cmd(CMD_SEARCH, 32'sd12345, 1'b0);
        queue_cmd(CMD_DELETE, -32'sd1, 1'b0);
        queue_cmd(CMD_DELETE, 32'sd12345, 1'b0);
        queue_cmd(CMD_RSVD_HI, 32'sd0, 1'b0);
        queue_cmd(CMD_DUMP,   32'sd0, 1'b0);
        queue_cmd(CMD_CLEAR,  32'sd0, 1'b0);

        // small value pool so searches and deletes find matches
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (int k = 5; k < 8; k++)
            value_pool[k] = $signed($urandom());

        // random mix; the sender drains now and then
        legal = 0;
        while (legal < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 36)
                c = CMD_INSERT;
            else if (r < 56)
                c = CMD_SEARCH;
            else if (r < 76)
                c = CMD_DELETE;
            else if (r < 86)
                c = CMD_DUMP;
            else if (r < 92)
                c = CMD_CLEAR;
            else if (r < 96)
                c = CMD_INSERT;
            else
                c = CMD_W'(CMD_RSVD_LO + $urandom_range(0, CMD_RSVD_HI - CMD_RSVD_LO));
            if ($urandom_range(0, 9) < 6)
                v = value_pool[$urandom_range(0, 7)];
            else
                v = $signed($urandom());
            queue_cmd(c, v, legal % 70 == 0);
            if (c < CMD_RSVD_LO)
                legal++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_ch.valid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d commands and %0d result words, list depth %0d.",
                 words_in, results_seen, LIST_DEPTH);
        $display("Statuses: ok %0d found %0d not found %0d empty %0d full %0d dumped %0d",
                 status_hits[ST_OK], status_hits[ST_FOUND], status_hits[ST_NOTFOUND],
                 status_hits[ST_EMPTY], status_hits[ST_FULL], status_hits[ST_DUMP]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
